/* design/pis_pkg.sv */
package pis_pkg;

  localparam int POS_W     = 24;
  localparam int VEL_W     = 16;
  localparam int SPD_W     = 16;
  localparam int T_W       = 32;
  localparam int H_W       = 43;
  localparam int AM_W      = 32;
  localparam int NM_W      = 43;
  localparam int Q_W       = 84;
  localparam int ROOT_W    = Q_W / 2;
  localparam int SQ_STEPS  = 3;
  localparam int DIV_STEPS = 4;

  localparam logic [SPD_W-1:0] SPEED_RESET = 16'd10000;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [VEL_W-1:0] vel_t;

  typedef enum logic [1:0] {
    ST_SOLVED     = 2'd0,
    ST_NO_ROOT    = 2'd1,
    ST_DEGENERATE = 2'd2
  } status_e;

  // Per-item context that rides along the root and divide pipelines
  typedef struct packed {
    pos_t [2:0]             tgt;
    vel_t [2:0]             vel;
    logic signed [H_W-1:0]  h;
    logic [AM_W-1:0]        am;
    logic                   a_neg;
    logic                   neg;
    status_e                status;
  } side_t;

  typedef struct packed {
    pos_t [2:0]             aim;
    logic signed [T_W-1:0]  t;
    status_e                status;
  } res_t;

endpackage

/* design/pis_ifs.sv */
interface pis_query_if
  import pis_pkg::*;
;
  logic valid;
  logic ready;
  pos_t source_x;
  pos_t source_y;
  pos_t source_z;
  pos_t target_x;
  pos_t target_y;
  pos_t target_z;
  vel_t velocity_x;
  vel_t velocity_y;
  vel_t velocity_z;

  modport source (
    output valid, source_x, source_y, source_z, target_x, target_y, target_z,
    output velocity_x, velocity_y, velocity_z,
    input  ready
  );
  modport sink (
    input  valid, source_x, source_y, source_z, target_x, target_y, target_z,
    input  velocity_x, velocity_y, velocity_z,
    output ready
  );
endinterface

interface pis_solution_if
  import pis_pkg::*;
;
  logic                  valid;
  logic                  ready;
  pos_t                  aim_x;
  pos_t                  aim_y;
  pos_t                  aim_z;
  logic signed [T_W-1:0] intercept_time;
  logic [1:0]            solve_status;

  modport source (
    output valid, aim_x, aim_y, aim_z, intercept_time, solve_status,
    input  ready
  );
  modport sink (
    input  valid, aim_x, aim_y, aim_z, intercept_time, solve_status,
    output ready
  );
endinterface

/* design/pis_sqrt.sv */
module pis_sqrt
  import pis_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vin,
  input  logic [Q_W-1:0]    rad,
  input  side_t             side_in,
  output logic              vout,
  output logic [ROOT_W-1:0] root,
  output side_t             side_out
);

  localparam int STAGES = ROOT_W / SQ_STEPS;
  localparam int RS_W   = ROOT_W + 1;
  localparam int W_W    = ROOT_W + 3;

  logic [STAGES-1:0] v;
  logic [RS_W-1:0]   rem_q [STAGES];
  logic [ROOT_W-1:0] rt_q  [STAGES];
  logic [Q_W-1:0]    rd_q  [STAGES];
  side_t             sd_q  [STAGES];

  logic [RS_W-1:0]   rem_in [STAGES];
  logic [ROOT_W-1:0] rt_in  [STAGES];
  logic [Q_W-1:0]    rd_in  [STAGES];

  logic [RS_W-1:0]   rem_next [STAGES];
  logic [ROOT_W-1:0] rt_next  [STAGES];
  logic [Q_W-1:0]    rd_next  [STAGES];

  always_comb begin
    rem_in[0] = '0;
    rt_in[0]  = '0;
    rd_in[0]  = rad;
    for (int k = 1; k < STAGES; k++) begin
      rem_in[k] = rem_q[k-1];
      rt_in[k]  = rt_q[k-1];
      rd_in[k]  = rd_q[k-1];
    end
  end

  // Digit-by-digit root: one radicand bit pair per step
  always_comb begin
    logic [RS_W-1:0]   r;
    logic [ROOT_W-1:0] rt;
    logic [Q_W-1:0]    rd;
    logic [W_W-1:0]    w;
    logic [W_W-1:0]    trial;
    for (int k = 0; k < STAGES; k++) begin
      r  = rem_in[k];
      rt = rt_in[k];
      rd = rd_in[k];
      for (int j = 0; j < SQ_STEPS; j++) begin
        w     = {r, rd[Q_W-1 -: 2]};
        trial = {1'b0, rt, 2'b01};
        rd    = {rd[Q_W-3:0], 2'b00};
        if (w >= trial) begin
          w  = w - trial;
          rt = {rt[ROOT_W-2:0], 1'b1};
        end else begin
          rt = {rt[ROOT_W-2:0], 1'b0};
        end
        r = w[RS_W-1:0];
      end
      rem_next[k] = r;
      rt_next[k]  = rt;
      rd_next[k]  = rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-2:0], vin};
    end
    if (en) begin
      for (int k = 0; k < STAGES; k++) begin
        rem_q[k] <= rem_next[k];
        rt_q[k]  <= rt_next[k];
        rd_q[k]  <= rd_next[k];
      end
      for (int k = STAGES - 1; k > 0; k--) begin
        sd_q[k] <= sd_q[k-1];
      end
      sd_q[0] <= side_in;
    end
  end

  assign vout     = v[STAGES-1];
  assign root     = rt_q[STAGES-1];
  assign side_out = sd_q[STAGES-1];

endmodule

/* design/pis_div.sv */
module pis_div
  import pis_pkg::*;
#(
  parameter int FRAC = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vin,
  input  logic [NM_W-1:0] nm,
  input  side_t           side_in,
  output logic            vout,
  output logic [T_W-1:0]  quo,
  output logic            ovf,
  output side_t           side_out
);

  localparam int STAGES = T_W / DIV_STEPS;
  localparam int SHIFT  = T_W - FRAC;

  logic [NM_W-1:0]      hi;
  logic [NM_W+FRAC-1:0] num;

  logic           e_v;
  logic [T_W-1:0] e_rem;
  logic [T_W-1:0] e_low;
  logic           e_ovf;
  side_t          e_sd;

  logic [STAGES-1:0] v;
  logic [STAGES-1:0] ovf_q;
  logic [T_W-1:0]    rem_q [STAGES];
  logic [T_W-1:0]    low_q [STAGES];
  logic [T_W-1:0]    q_q   [STAGES];
  side_t             sd_q  [STAGES];

  logic [T_W-1:0]  rem_in [STAGES];
  logic [T_W-1:0]  low_in [STAGES];
  logic [T_W-1:0]  q_in   [STAGES];
  logic [AM_W-1:0] d_in   [STAGES];

  logic [T_W-1:0] rem_next [STAGES];
  logic [T_W-1:0] low_next [STAGES];
  logic [T_W-1:0] q_next   [STAGES];

  // Upper part of the shifted dividend; a quotient of 2^32 or more sets ovf
  assign hi  = nm >> SHIFT;
  assign num = {nm, {FRAC{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (en) begin
      e_v <= vin;
    end
    if (en) begin
      e_rem <= hi[T_W-1:0];
      e_low <= num[T_W-1:0];
      e_ovf <= (hi >= NM_W'(side_in.am));
      e_sd  <= side_in;
    end
  end

  always_comb begin
    rem_in[0] = e_rem;
    low_in[0] = e_low;
    q_in[0]   = '0;
    d_in[0]   = e_sd.am;
    for (int k = 1; k < STAGES; k++) begin
      rem_in[k] = rem_q[k-1];
      low_in[k] = low_q[k-1];
      q_in[k]   = q_q[k-1];
      d_in[k]   = sd_q[k-1].am;
    end
  end

  // Restoring division, one quotient bit per step
  always_comb begin
    logic [T_W-1:0]  r;
    logic [T_W-1:0]  lo;
    logic [T_W-1:0]  qq;
    logic [T_W:0]    w;
    for (int k = 0; k < STAGES; k++) begin
      r  = rem_in[k];
      lo = low_in[k];
      qq = q_in[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        w  = {r, lo[T_W-1]};
        lo = {lo[T_W-2:0], 1'b0};
        if (w >= {1'b0, d_in[k]}) begin
          w  = w - {1'b0, d_in[k]};
          qq = {qq[T_W-2:0], 1'b1};
        end else begin
          qq = {qq[T_W-2:0], 1'b0};
        end
        r = w[T_W-1:0];
      end
      rem_next[k] = r;
      low_next[k] = lo;
      q_next[k]   = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[STAGES-2:0], e_v};
    end
    if (en) begin
      ovf_q <= {ovf_q[STAGES-2:0], e_ovf};
      for (int k = 0; k < STAGES; k++) begin
        rem_q[k] <= rem_next[k];
        low_q[k] <= low_next[k];
        q_q[k]   <= q_next[k];
      end
      for (int k = STAGES - 1; k > 0; k--) begin
        sd_q[k] <= sd_q[k-1];
      end
      sd_q[0] <= e_sd;
    end
  end

  assign vout     = v[STAGES-1];
  assign quo      = q_q[STAGES-1];
  assign ovf      = ovf_q[STAGES-1];
  assign side_out = sd_q[STAGES-1];

endmodule

/* design/projectile_intercept_solver.sv */
// Channel    Dir  Payload
// query      in   source_x/y/z, target_x/y/z, velocity_x/y/z
// solution   out  aim_x/y/z, intercept_time, solve_status
// cfg_wr_*   in   projectile_speed (16 bit)
//
// One query per cycle while the output buffer is not full.
// The pipeline includes the 14-stage square root (three root bits a stage)
// and the divider (four quotient bits a stage).
// rst is synchronous and restores projectile speed 10000.
// A two-entry output buffer lets queries enter while a result waits;
// the pipeline holds only when that buffer is full.
module projectile_intercept_solver
  import pis_pkg::*;
#(
  parameter int TIME_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [SPD_W-1:0]   cfg_wr_data,
  pis_query_if.sink          query,
  pis_solution_if.source     solution
);

  localparam int A_W    = 34;
  localparam int HM_W   = 41;
  localparam int HL_W   = 21;
  localparam int C_W    = 50;
  localparam int CL_W   = 25;
  localparam int HH_W   = 82;
  localparam int PROD_W = T_W + VEL_W;

  localparam logic [T_W:0] MAG_NEG_MAX = 33'h0_8000_0000;
  localparam logic [T_W:0] MAG_POS_MAX = 33'h0_7FFF_FFFF;
  localparam logic signed [PROD_W:0] AIM_MAX = 49'sd8388607;
  localparam logic signed [PROD_W:0] AIM_MIN = -49'sd8388608;

  logic [SPD_W-1:0] speed;
  logic             adv;
  logic [1:0]       cnt;
  logic             push;
  logic             pop;

  pos_t src_in [3];
  pos_t tgt_in [3];
  vel_t vel_in [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= SPEED_RESET;
    end else if (cfg_wr_en) begin
      speed <= cfg_wr_data;
    end
  end

  assign src_in[0] = query.source_x;
  assign src_in[1] = query.source_y;
  assign src_in[2] = query.source_z;
  assign tgt_in[0] = query.target_x;
  assign tgt_in[1] = query.target_y;
  assign tgt_in[2] = query.target_z;
  assign vel_in[0] = query.velocity_x;
  assign vel_in[1] = query.velocity_y;
  assign vel_in[2] = query.velocity_z;

  assign adv         = (cnt != 2'd2);
  assign query.ready = adv;

  // Stage 1: offsets and squared speeds
  logic                   v1;
  pos_t                   tgt1 [3];
  vel_t                   vel1 [3];
  logic signed [POS_W:0]  d1   [3];
  logic [2*VEL_W-2:0]     vv1  [3];
  logic [2*SPD_W-1:0]     ss1;

  always_ff @(posedge clk) begin
    logic signed [2*VEL_W-1:0] vsq;
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= query.valid;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        tgt1[i] <= tgt_in[i];
        vel1[i] <= vel_in[i];
        d1[i]   <= {tgt_in[i][POS_W-1], tgt_in[i]} - {src_in[i][POS_W-1], src_in[i]};
        vsq     = vel_in[i] * vel_in[i];
        vv1[i]  <= vsq[2*VEL_W-2:0];
      end
      ss1 <= speed * speed;
    end
  end

  // Stage 2: dot-product terms and a
  logic                        v2;
  pos_t                        tgt2 [3];
  vel_t                        vel2 [3];
  logic signed [POS_W+VEL_W:0] ph2  [3];
  logic [2*POS_W:0]            pc2  [3];
  logic signed [A_W-1:0]       a2;

  always_ff @(posedge clk) begin
    logic signed [2*POS_W+1:0] sq;
    logic [2*VEL_W:0]          vvsum;
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        tgt2[i] <= tgt1[i];
        vel2[i] <= vel1[i];
        ph2[i]  <= d1[i] * vel1[i];
        sq      = d1[i] * d1[i];
        pc2[i]  <= sq[2*POS_W:0];
      end
      vvsum = {2'b00, vv1[0]} + {2'b00, vv1[1]} + {2'b00, vv1[2]};
      a2    <= $signed({1'b0, vvsum}) - $signed({2'b00, ss1});
    end
  end

  // Stage 3: h, c and |a|
  logic              v3;
  side_t             sd3;
  logic [C_W-1:0]    c3;

  always_ff @(posedge clk) begin
    logic signed [A_W-1:0] na;
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      na = -a2;
      for (int i = 0; i < 3; i++) begin
        sd3.tgt[i] <= tgt2[i];
        sd3.vel[i] <= vel2[i];
      end
      sd3.h      <= ph2[0] + ph2[1] + ph2[2];
      sd3.am     <= a2[A_W-1] ? na[AM_W-1:0] : a2[AM_W-1:0];
      sd3.a_neg  <= a2[A_W-1];
      sd3.neg    <= 1'b0;
      sd3.status <= ST_SOLVED;
      c3         <= {1'b0, pc2[0]} + {1'b0, pc2[1]} + {1'b0, pc2[2]};
    end
  end

  // Stage 4: |h|
  logic            v4;
  side_t           sd4;
  logic [C_W-1:0]  c4;
  logic [HM_W-1:0] hm4;

  always_ff @(posedge clk) begin
    logic signed [H_W-1:0] nh;
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      nh  = -sd3.h;
      hm4 <= sd3.h[H_W-1] ? nh[HM_W-1:0] : sd3.h[HM_W-1:0];
      c4  <= c3;
      sd4 <= sd3;
    end
  end

  // Stage 5: partial products of h^2 and |a|*c
  logic                     v5;
  side_t                    sd5;
  logic [2*HL_W-1:0]        pp0;
  logic [2*HL_W-2:0]        pp1;
  logic [2*HL_W-3:0]        pp2;
  logic [AM_W+CL_W-1:0]     ac0;
  logic [AM_W+CL_W-1:0]     ac1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      pp0 <= hm4[HL_W-1:0] * hm4[HL_W-1:0];
      pp1 <= hm4[HL_W-1:0] * hm4[HM_W-1:HL_W];
      pp2 <= hm4[HM_W-1:HL_W] * hm4[HM_W-1:HL_W];
      ac0 <= sd4.am * c4[CL_W-1:0];
      ac1 <= sd4.am * c4[C_W-1:CL_W];
      sd5 <= sd4;
    end
  end

  // Stage 6: assemble h^2 and |a|*c
  logic            v6;
  side_t           sd6;
  logic [HH_W-1:0] hh6;
  logic [HH_W-1:0] ac6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
    if (adv) begin
      hh6 <= {pp2, {(2*HL_W){1'b0}}} + {pp1, {(HL_W+1){1'b0}}} + pp0;
      ac6 <= {ac1, {CL_W{1'b0}}} + ac0;
      sd6 <= sd5;
    end
  end

  // Stage 7: quarter discriminant and status
  logic           v7;
  side_t          sd7;
  logic [Q_W-1:0] q7;

  always_ff @(posedge clk) begin
    side_t s;
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
    if (adv) begin
      s = sd6;
      if (sd6.am == '0) begin
        s.status = ST_DEGENERATE;
      end else if (!sd6.a_neg && (hh6 < ac6)) begin
        s.status = ST_NO_ROOT;
      end else begin
        s.status = ST_SOLVED;
      end
      sd7 <= s;
      if (sd6.a_neg) begin
        q7 <= {2'b00, hh6} + {2'b00, ac6};
      end else begin
        q7 <= {2'b00, hh6} - {2'b00, ac6};
      end
    end
  end

  logic              vr;
  logic [ROOT_W-1:0] root;
  side_t             sdr;

  pis_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (v7),
    .rad      (q7),
    .side_in  (sd7),
    .vout     (vr),
    .root     (root),
    .side_out (sdr)
  );

  // Stage 8: numerator -h - r and its magnitude
  logic            v8;
  side_t           sd8;
  logic [NM_W-1:0] nm8;

  always_ff @(posedge clk) begin
    logic [H_W+1:0] n;
    logic [H_W+1:0] nabs;
    side_t          s;
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= vr;
    end
    if (adv) begin
      n     = '0 - {{2{sdr.h[H_W-1]}}, sdr.h} - {3'b000, root};
      nabs  = n[H_W+1] ? ('0 - n) : n;
      s     = sdr;
      s.neg = n[H_W+1] ^ sdr.a_neg;
      nm8   <= nabs[NM_W-1:0];
      sd8   <= s;
    end
  end

  logic           vd;
  logic [T_W-1:0] quo;
  logic           ovf;
  side_t          sdd;

  pis_div #(
    .FRAC (TIME_FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .vin      (v8),
    .nm       (nm8),
    .side_in  (sd8),
    .vout     (vd),
    .quo      (quo),
    .ovf      (ovf),
    .side_out (sdd)
  );

  // Stage 9: signed, saturated time
  logic                  v9;
  side_t                 sd9;
  logic signed [T_W-1:0] t9;

  always_ff @(posedge clk) begin
    logic [T_W:0] mag;
    logic [T_W:0] mneg;
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= vd;
    end
    if (adv) begin
      mag  = ovf ? {1'b1, {T_W{1'b0}}} : {1'b0, quo};
      mneg = '0 - ((mag > MAG_NEG_MAX) ? MAG_NEG_MAX : mag);
      if (sdd.status != ST_SOLVED) begin
        t9 <= '0;
      end else if (sdd.neg) begin
        t9 <= mneg[T_W-1:0];
      end else begin
        t9 <= (mag > MAG_POS_MAX) ? MAG_POS_MAX[T_W-1:0] : mag[T_W-1:0];
      end
      sd9 <= sdd;
    end
  end

  // Stage 10: displacement products
  logic                     v10;
  pos_t                     tgt10  [3];
  logic signed [PROD_W-1:0] prod10 [3];
  logic signed [T_W-1:0]    t10;
  status_e                  st10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v10 <= 1'b0;
    end else if (adv) begin
      v10 <= v9;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        tgt10[i]  <= $signed(sd9.tgt[i]);
        prod10[i] <= t9 * $signed(sd9.vel[i]);
      end
      t10  <= t9;
      st10 <= sd9.status;
    end
  end

  // Aim point: floor shift, add, saturate
  res_t res_in;

  always_comb begin
    logic signed [PROD_W-1:0] sh;
    logic signed [PROD_W:0]   sum;
    res_in.t      = t10;
    res_in.status = st10;
    for (int i = 0; i < 3; i++) begin
      sh  = prod10[i] >>> TIME_FRAC_BITS;
      sum = tgt10[i] + sh;
      if (sum > AIM_MAX) begin
        res_in.aim[i] = AIM_MAX[POS_W-1:0];
      end else if (sum < AIM_MIN) begin
        res_in.aim[i] = AIM_MIN[POS_W-1:0];
      end else begin
        res_in.aim[i] = sum[POS_W-1:0];
      end
    end
  end

  // Two-entry output buffer, head in buf0
  res_t buf0;
  res_t buf1;

  assign push = v10 && adv;
  assign pop  = solution.valid && solution.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
    case ({push, pop})
      2'b10: begin
        if (cnt == 2'd0) begin
          buf0 <= res_in;
        end else begin
          buf1 <= res_in;
        end
      end
      2'b01: begin
        buf0 <= buf1;
      end
      2'b11: begin
        if (cnt == 2'd1) begin
          buf0 <= res_in;
        end else begin
          buf0 <= buf1;
          buf1 <= res_in;
        end
      end
      default: begin
        buf0 <= buf0;
      end
    endcase
  end

  assign solution.valid          = (cnt != 2'd0);
  assign solution.aim_x          = buf0.aim[0];
  assign solution.aim_y          = buf0.aim[1];
  assign solution.aim_z          = buf0.aim[2];
  assign solution.intercept_time = buf0.t;
  assign solution.solve_status   = buf0.status;

  a_unsolved_time_zero: assert property (@(posedge clk) disable iff (rst)
    solution.valid && (solution.solve_status != ST_SOLVED) |-> solution.intercept_time == '0)
    else $error("unsolved item carries nonzero time");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt != 2'd3)
    else $error("output buffer overflow");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> cnt == $past(cnt) - 2'd1)
    else $error("output buffer count did not drop on pop");

endmodule

/* tb/sv/projectile_intercept_solver_test.sv */
`timescale 1ns / 1ps
module projectile_intercept_solver_test
  import pis_pkg::*;
;

  localparam int FRAC = 16;
  localparam int LATENCY = 34;

  typedef struct {
    pos_t [2:0] aim;
    logic signed [T_W-1:0] t;
    status_e status;
  } solution_t;

  class intercept_board;
    solution_t pending[$];
    logic [SPD_W-1:0] speed;
    int mismatches;
    int checked;
    int status_seen[3];

    function new();
      speed = SPEED_RESET;
      mismatches = 0;
      checked = 0;
    endfunction

    // Exact intercept time and aim point for one query
    function void note_query(pos_t src[3], pos_t tgt[3], vel_t vel[3]);
      longint signed dif[3];
      longint signed h, a, t, p;
      logic signed [127:0] q, root, cand, n, nm, am, quo, rem, mag, c;
      solution_t s;
      logic neg;
      h = 0;
      c = 0;
      t = 0;
      s.status = ST_SOLVED;
      for (int i = 0; i < 3; i++) begin
        dif[i] = longint'(tgt[i]) - longint'(src[i]);
        h += longint'(vel[i]) * dif[i];
        c += 128'(dif[i]) * 128'(dif[i]);
      end
      a = longint'(vel[0]) * vel[0] + longint'(vel[1]) * vel[1] + longint'(vel[2]) * vel[2]
          - longint'(speed) * longint'(speed);
      if (a == 0) begin
        s.status = ST_DEGENERATE;
      end else begin
        q = 128'(h) * 128'(h) - 128'(a) * c;
        if (q < 0) begin
          s.status = ST_NO_ROOT;
        end else begin
          root = 0;
          for (int i = 63; i >= 0; i--) begin
            cand = root | (128'sd1 << i);
            if (cand * cand <= q) root = cand;
          end
          n = -128'(h) - root;
          nm = n < 0 ? -n : n;
          am = a < 0 ? -128'(a) : 128'(a);
          quo = nm / am;
          rem = nm % am;
          neg = (n < 0) != (a < 0);
          if (quo >= (128'sd1 << (32 - FRAC))) mag = 128'sd1 << 32;
          else mag = (quo << FRAC) + (rem << FRAC) / am;
          if (neg) begin
            if (mag > 128'sh80000000) mag = 128'sh80000000;
            t = -longint'(mag);
          end else begin
            if (mag > 128'sh7FFFFFFF) mag = 128'sh7FFFFFFF;
            t = longint'(mag);
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        p = longint'(tgt[i]) + ((t * vel[i]) >>> FRAC);
        if (p < -8388608) p = -8388608;
        if (p > 8388607) p = 8388607;
        s.aim[i] = pos_t'(p);
      end
      s.t = t[31:0];
      pending.push_back(s);
    endfunction

    function void check_solution(pos_t ax, pos_t ay, pos_t az, logic [T_W-1:0] t,
                                 logic [1:0] st);
      solution_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected solution: aim %0d %0d %0d t %0d",
                                       ax, ay, az, $signed(t));
        return;
      end
      e = pending.pop_front();
      status_seen[e.status]++;
      if (ax !== e.aim[0] || ay !== e.aim[1] || az !== e.aim[2] || t !== e.t ||
          st !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected aim %0d %0d %0d t %0d st %0d, got %0d %0d %0d t %0d st %0d",
                   e.aim[0], e.aim[1], e.aim[2], e.t, e.status,
                   ax, ay, az, $signed(t), st);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [SPD_W-1:0] cfg_wr_data;
  int send_idle;
  int recv_idle;
  int hold_off;

  pis_query_if query ();
  pis_solution_if solution ();

  projectile_intercept_solver DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .query(query),
    .solution(solution)
  );

  intercept_board board = new();

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("projectile_intercept_solver regression: fail");
    $finish;
  end

  // Count down the long receiver hold-off
  always @(posedge clk) begin
    if (hold_off > 0) hold_off <= hold_off - 1;
  end

  // Receiver: random stalls plus a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      solution.ready <= 1'b0;
    end else begin
      if (solution.valid && solution.ready)
        board.check_solution(solution.aim_x, solution.aim_y, solution.aim_z,
                             solution.intercept_time, solution.solve_status);
      if (hold_off > 0) begin
        solution.ready <= 1'b0;
      end else begin
        solution.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  function automatic pos_t rand_pos(int mode);
    case (mode)
      0: return pos_t'($urandom);
      1: return pos_t'($signed($urandom_range(4000)) - 2000);
      2: return 24'sh7FFFFF;
      default: return 24'sh800000;
    endcase
  endfunction

  function automatic vel_t rand_vel(int mode);
    case (mode)
      0: return vel_t'($urandom);
      1: return vel_t'($signed($urandom_range(6000)) - 3000);
      2: return 16'sh7FFF;
      default: return 16'sh8000;
    endcase
  endfunction

  task automatic send_query(pos_t src[3], pos_t tgt[3], vel_t vel[3]);
    while ($urandom_range(99) < send_idle) begin
      query.valid <= 1'b0;
      @(posedge clk);
    end
    query.valid <= 1'b1;
    query.source_x <= src[0];
    query.source_y <= src[1];
    query.source_z <= src[2];
    query.target_x <= tgt[0];
    query.target_y <= tgt[1];
    query.target_z <= tgt[2];
    query.velocity_x <= vel[0];
    query.velocity_y <= vel[1];
    query.velocity_z <= vel[2];
    @(posedge clk);
    while (!query.ready) @(posedge clk);
    board.note_query(src, tgt, vel);
  endtask

  task automatic send_random(int mode);
    pos_t src[3], tgt[3];
    vel_t vel[3];
    for (int i = 0; i < 3; i++) begin
      src[i] = rand_pos(mode == 0 ? 0 : ($urandom_range(9) == 0 ? $urandom_range(3) : 1));
      tgt[i] = rand_pos(mode == 0 ? 0 : ($urandom_range(9) == 0 ? $urandom_range(3) : 1));
      vel[i] = rand_vel(mode == 0 ? 0 : ($urandom_range(9) == 0 ? $urandom_range(3) : 1));
    end
    send_query(src, tgt, vel);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    query.valid <= 1'b0;
    while (board.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_speed(logic [SPD_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.speed = v;
    @(posedge clk);
  endtask

  task automatic directed();
    pos_t src[3], tgt[3];
    vel_t vel[3];
    // corner mixes of random, small, maximum and minimum values
    for (int k = 0; k < 12; k++) begin
      for (int i = 0; i < 3; i++) begin
        src[i] = rand_pos(k % 4);
        tgt[i] = rand_pos((k + 1 + i) % 4);
        vel[i] = rand_vel((k + i) % 4);
      end
      send_query(src, tgt, vel);
    end
    // stationary target, coincident positions
    for (int i = 0; i < 3; i++) begin
      src[i] = 0; tgt[i] = 0; vel[i] = 0;
    end
    send_query(src, tgt, vel);
    // target speed matched to projectile speed where it fits: a is zero
    vel[0] = vel_t'(board.speed[15] ? 16'sh7FFF : board.speed);
    tgt[0] = 1000;
    send_query(src, tgt, vel);
    // fast receding target: no real root at the reset speed
    vel[0] = 16'sh7FFF; vel[1] = 16'sh7FFF; tgt[0] = 500;
    send_query(src, tgt, vel);
    // approaching fast: positive intercept time
    vel[0] = 16'sh8000; vel[1] = 0; tgt[0] = 24'sh7FFFFF;
    send_query(src, tgt, vel);
  endtask

  initial begin
    int phase_items;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    query.valid = 1'b0;
    query.source_x = '0; query.source_y = '0; query.source_z = '0;
    query.target_x = '0; query.target_y = '0; query.target_z = '0;
    query.velocity_x = '0; query.velocity_y = '0; query.velocity_z = '0;
    solution.ready = 1'b0;
    hold_off = 0;
    send_idle = 38;
    recv_idle = 59;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle = 38; recv_idle = 59; end
        1: begin send_idle = 59; recv_idle = 38; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      drain();
      case (ph)
        0: set_speed(16'd0);
        1: set_speed(16'hFFFF);
        2: set_speed(16'd3000);
        3: set_speed(16'd40000);
        4: set_speed(16'd10000);
        default: set_speed(16'($urandom_range(65535)));
      endcase
      if (ph == 2) hold_off = 300;
      phase_items = 65;
      for (int k = 0; k < phase_items; k++) send_random($urandom_range(3) == 0 ? 0 : 1);
      if (ph == 1) directed();
    end
    drain();
    $display("checked %0d solutions: %0d solved, %0d no root, %0d degenerate",
             board.checked, board.status_seen[0], board.status_seen[1],
             board.status_seen[2]);
    $display("speeds swept from zero to full scale with stalls on both sides");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("projectile_intercept_solver regression: pass");
    end else begin
      $display("projectile_intercept_solver regression: fail");
    end
    $finish;
  end

endmodule
